>>> rtl/core/circular_deque_engine_assert.svh
// Assertion macros shared by the deque engine RTL.
// Included by files that check their own logic; no other dependencies.
`ifndef CIRCULAR_DEQUE_ENGINE_ASSERT_SVH
`define CIRCULAR_DEQUE_ENGINE_ASSERT_SVH

// Same-cycle implication, quiet during reset.
`define CDE_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("deque engine check failed");

// Next-cycle implication, quiet during reset.
`define CDE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("deque engine check failed");

`endif

>>> rtl/core/cde_pkg.sv
// Package for the circular deque engine: constants, command codes, payload
// and control structs. No dependencies.
package cde_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int DATA_W    = 32;
	localparam int CAP_W     = 5;
	localparam int CMD_W     = 3;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_PUSH_BACK  = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_POP_BACK   = 3'd3,
		CMD_PEEK_FRONT = 3'd4,
		CMD_PEEK_BACK  = 3'd5
	} cmd_t;

	typedef struct packed {
		logic [CMD_W-1:0]         cmd;
		logic signed [DATA_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic                     ok;
		logic signed [DATA_W-1:0] data;
		logic                     empty_res;
		logic                     full_res;
	} res_t;

	// Result control handed from the pointer unit to the output stage.
	typedef struct packed {
		logic ok;
		logic use_mem;   // data comes from the ring read port
		logic fill_ones; // peek into an empty deque
		logic empty;
		logic full;
	} res_ctl_t;

endpackage

>>> rtl/core/cde_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies beyond the package defaults.
module cde_ram #(
	parameter int WIDTH = cde_pkg::DATA_W,
	parameter int DEPTH = cde_pkg::DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/core/cde_ctrl.sv
// Pointer unit of the deque engine: head, tail, occupancy and capacity,
// ring access control. Depends on cde_pkg and the assertion header.
`include "circular_deque_engine_assert.svh"

module cde_ctrl #(
	parameter int DEPTH = cde_pkg::DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        fire,
	input  logic [cde_pkg::CMD_W-1:0]   cmd,
	input  logic                        cfg_wr,
	input  logic [cde_pkg::CAP_W-1:0]   cfg_data,
	output logic                        we,
	output logic [$clog2(DEPTH)-1:0]    waddr,
	output logic                        re,
	output logic [$clog2(DEPTH)-1:0]    raddr,
	output cde_pkg::res_ctl_t           res_ctl
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [PTR_W-1:0] head_q, tail_q, head_n, tail_n;
	logic [CNT_W-1:0] occ_q, occ_n, cap_q, cap_n;
	logic             empty, full;

	function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p,
			input logic [CNT_W-1:0] cap);
		logic [CNT_W:0] inc;
		inc = (CNT_W+1)'(p) + 1'b1;
		return (inc >= (CNT_W+1)'(cap)) ? '0 : PTR_W'(inc);
	endfunction

	function automatic logic [PTR_W-1:0] ring_prev(input logic [PTR_W-1:0] p,
			input logic [CNT_W-1:0] cap);
		return (p == '0) ? PTR_W'(cap - 1'b1) : p - 1'b1;
	endfunction

	assign empty = (occ_q == '0);
	assign full  = (occ_q >= cap_q);

	always_comb begin
		head_n  = head_q;
		tail_n  = tail_q;
		occ_n   = occ_q;
		we      = 1'b0;
		waddr   = '0;
		re      = 1'b0;
		raddr   = head_q;
		res_ctl = '0;
		unique case (cde_pkg::cmd_t'(cmd))
			cde_pkg::CMD_PUSH_FRONT, cde_pkg::CMD_PUSH_BACK: begin
				if (!full) begin
					if (empty) begin
						head_n = '0;
						tail_n = '0;
						waddr  = '0;
					end else if (cde_pkg::cmd_t'(cmd) == cde_pkg::CMD_PUSH_FRONT) begin
						head_n = ring_prev(head_q, cap_q);
						waddr  = head_n;
					end else begin
						tail_n = ring_next(tail_q, cap_q);
						waddr  = tail_n;
					end
					we          = fire;
					occ_n       = occ_q + 1'b1;
					res_ctl.ok  = 1'b1;
				end
			end
			cde_pkg::CMD_POP_FRONT, cde_pkg::CMD_POP_BACK: begin
				if (!empty) begin
					if (occ_q == CNT_W'(1)) begin
						head_n = '0;
						tail_n = '0;
					end else if (cde_pkg::cmd_t'(cmd) == cde_pkg::CMD_POP_FRONT) begin
						head_n = ring_next(head_q, cap_q);
					end else begin
						tail_n = ring_prev(tail_q, cap_q);
					end
					occ_n      = occ_q - 1'b1;
					res_ctl.ok = 1'b1;
				end
			end
			cde_pkg::CMD_PEEK_FRONT, cde_pkg::CMD_PEEK_BACK: begin
				if (empty) begin
					res_ctl.fill_ones = 1'b1;
				end else begin
					raddr = (cde_pkg::cmd_t'(cmd) == cde_pkg::CMD_PEEK_FRONT) ? head_q : tail_q;
					re              = fire;
					res_ctl.use_mem = 1'b1;
					res_ctl.ok      = 1'b1;
				end
			end
			default: begin
			end
		endcase
		res_ctl.empty = (occ_n == '0);
		res_ctl.full  = (occ_n >= cap_q);
	end

	// Clamp the written capacity into 1..DEPTH.
	always_comb begin
		if (cfg_data == '0) begin
			cap_n = CNT_W'(1);
		end else if (int'(cfg_data) > DEPTH) begin
			cap_n = CNT_W'(DEPTH);
		end else begin
			cap_n = CNT_W'(cfg_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			occ_q  <= '0;
			cap_q  <= CNT_W'(DEPTH);
		end else if (cfg_wr) begin
			head_q <= '0;
			tail_q <= '0;
			occ_q  <= '0;
			cap_q  <= cap_n;
		end else if (fire) begin
			head_q <= head_n;
			tail_q <= tail_n;
			occ_q  <= occ_n;
		end
	end

	`CDE_ASSERT_IMPLIES(a_occ_le_cap, clk, arst_n, 1'b1, occ_q <= cap_q)
	`CDE_ASSERT_IMPLIES(a_single_same, clk, arst_n, occ_q == CNT_W'(1), head_q == tail_q)
	`CDE_ASSERT_NEXT(a_push_grows, clk, arst_n, fire && !cfg_wr && we, occ_q == $past(occ_q) + 1'b1)

endmodule

>>> rtl/core/circular_deque_engine.sv
// Circular deque engine: the done strobe comes in the cycle after a command is accepted.
// Throughput is one command per cycle; busy stays low, push writes and peek reads
// share the single ring RAM, and the output stage is one register behind it.
// Reset (arst_n low) empties the deque and sets capacity to DEPTH; the ring RAM
// keeps no reset and is only read at slots that hold live entries.
// Depends on cde_pkg, cde_ctrl, cde_ram and the assertion header.
`include "circular_deque_engine_assert.svh"

module circular_deque_engine #(
	parameter int DEPTH = cde_pkg::DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// command channel
	input  logic                      start,
	output logic                      busy,
	input  cde_pkg::req_t             req,
	// result channel, one-cycle strobe, no back-pressure
	output logic                      done,
	output cde_pkg::res_t             res,
	// capacity write channel
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [cde_pkg::CAP_W-1:0] cfg_data
);

	localparam int PTR_W = $clog2(DEPTH);

	logic                      fire;
	logic                      cfg_wr;
	logic                      ram_we, ram_re;
	logic [PTR_W-1:0]          ram_waddr, ram_raddr;
	logic [cde_pkg::DATA_W-1:0] ram_rdata;
	cde_pkg::res_ctl_t         res_ctl;

	logic                      valid_s1;
	cde_pkg::res_ctl_t         ctl_s1;

	// Every command not met by a capacity write finishes its state update at the accept
	// edge, so a new transaction is taken every cycle.
	assign busy      = 1'b0;
	assign fire      = start && !busy;
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	// Pointer unit: decides the ring access and the flags after the step.
	cde_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.cmd      (req.cmd),
		.cfg_wr   (cfg_wr),
		.cfg_data (cfg_data),
		.we       (ram_we),
		.waddr    (ram_waddr),
		.re       (ram_re),
		.raddr    (ram_raddr),
		.res_ctl  (res_ctl)
	);

	// Ring store. A push writes at the accept edge; a peek in the next cycle
	// reads at the following edge, so the written word is already there.
	cde_ram #(
		.WIDTH(cde_pkg::DATA_W),
		.DEPTH(DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (req.value),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Output stage: hold the result control alongside the RAM read cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= fire;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			ctl_s1 <= res_ctl;
		end
	end

	// Assemble the result: peeked word from the RAM, all ones for a peek into
	// an empty deque, zero for everything else.
	always_comb begin
		res.ok        = ctl_s1.ok;
		res.empty_res = ctl_s1.empty;
		res.full_res  = ctl_s1.full;
		if (ctl_s1.use_mem) begin
			res.data = ram_rdata;
		end else if (ctl_s1.fill_ones) begin
			res.data = '1;
		end else begin
			res.data = '0;
		end
	end

	assign done = valid_s1;

	`CDE_ASSERT_NEXT(a_done_follows, clk, arst_n, fire, done)
	`CDE_ASSERT_NEXT(a_no_spurious_done, clk, arst_n, !fire, !done)
	`CDE_ASSERT_IMPLIES(a_flags_exclusive, clk, arst_n, done, !(res.empty_res && res.full_res))

endmodule
